@@ rtl/safk_pkg.sv @@
// Package: shared types and constants of the serial arm kinematics block.
package safk_pkg;

    localparam int unsigned AngleW = 16;
    localparam int unsigned IdxW = 3;
    localparam int unsigned RotW = 18;
    localparam int unsigned PosW = 32;
    localparam int unsigned LenW = 16;
    localparam int unsigned ZW = 22;
    localparam int unsigned CordicSteps = 16;
    localparam int unsigned StepW = 4;

    localparam logic signed [ZW-1:0] HalfPiQ16 = 22'sd102944;
    localparam logic signed [ZW-1:0] PiQ16 = 22'sd205887;
    localparam logic signed [RotW-1:0] OneQ16 = 18'sd65536;
    localparam logic signed [RotW-1:0] CordicGain = 18'sd39797;
    localparam logic [LenW-1:0] LinkReset = 16'd22938;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_CORDIC,
        ST_FIX,
        ST_OFFSET,
        ST_MIX,
        ST_CENTER,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic fold;
        logic cordic;
        logic fix;
        logic restart;
        logic offset_full;
        logic offset_half;
        logic mix;
        logic center;
        logic [1:0] row;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cordic_last;
    } t_status;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [StepW-1:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            4'd0: v = 22'sd51472;
            4'd1: v = 22'sd30386;
            4'd2: v = 22'sd16055;
            4'd3: v = 22'sd8150;
            4'd4: v = 22'sd4091;
            4'd5: v = 22'sd2047;
            4'd6: v = 22'sd1024;
            4'd7: v = 22'sd512;
            4'd8: v = 22'sd256;
            4'd9: v = 22'sd128;
            4'd10: v = 22'sd64;
            4'd11: v = 22'sd32;
            4'd12: v = 22'sd16;
            4'd13: v = 22'sd8;
            4'd14: v = 22'sd4;
            default: v = 22'sd2;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/safk_if.sv @@
// Interfaces: input and result channels with valid/ready handshake.
interface safk_in_if;
    import safk_pkg::*;
    logic valid;
    logic ready;
    logic signed [AngleW-1:0] joint_angle;
    logic [IdxW-1:0] joint_index;
    modport source (output valid, output joint_angle, output joint_index, input ready);
    modport sink (input valid, input joint_angle, input joint_index, output ready);
endinterface

interface safk_out_if;
    import safk_pkg::*;
    logic valid;
    logic ready;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [RotW-1:0] rot_00;
    logic signed [RotW-1:0] rot_01;
    logic signed [RotW-1:0] rot_02;
    logic signed [RotW-1:0] rot_10;
    logic signed [RotW-1:0] rot_11;
    logic signed [RotW-1:0] rot_12;
    logic signed [RotW-1:0] rot_20;
    logic signed [RotW-1:0] rot_21;
    logic signed [RotW-1:0] rot_22;
    modport source (output valid, output pos_x, output pos_y, output pos_z,
        output rot_00, output rot_01, output rot_02, output rot_10, output rot_11,
        output rot_12, output rot_20, output rot_21, output rot_22, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
        input rot_00, input rot_01, input rot_02, input rot_10, input rot_11,
        input rot_12, input rot_20, input rot_21, input rot_22, output ready);
endinterface

@@ rtl/safk_ctrl.sv @@
// Controller: sequences fold, CORDIC, offset, mix and center steps per item.
module safk_ctrl
    import safk_pkg::*;
#(
    parameter int unsigned NUM_JOINTS = 7
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic [IdxW-1:0] i_joint_index,
    input  t_status i_status,
    output t_cmd o_cmd,
    output logic o_out_valid,
    input  logic i_out_ready
);

    t_state r_state, n_state;
    logic [1:0] r_row, n_row;
    logic [1:0] r_fold, n_fold;
    logic [IdxW-1:0] r_idx;
    logic r_ovalid, n_ovalid;
    logic accept;
    logic is_end;
    logic center_wait;

    assign accept = i_in_valid && o_in_ready;
    assign is_end = ({1'b0, r_idx} == (IdxW+1)'(NUM_JOINTS));
    // The center step overwrites the output registers, so it waits for a pending beat.
    assign center_wait = r_ovalid && (r_row == 2'd0);

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row <= '0;
            r_fold <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_fold <= n_fold;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= i_joint_index;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_fold = r_fold;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_FOLD;
                    n_fold = '0;
                end
            end
            ST_FOLD: begin
                n_fold = r_fold + 2'd1;
                if (r_fold == 2'd3) begin
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (i_status.cordic_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_row = '0;
                if (r_idx == '0) begin
                    n_state = ST_CENTER;
                end else begin
                    n_state = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                n_row = r_row + 2'd1;
                if (r_row == 2'd2) begin
                    n_row = '0;
                    n_state = is_end ? ST_CENTER : ST_MIX;
                end
            end
            ST_MIX: begin
                n_row = r_row + 2'd1;
                if (r_row == 2'd2) begin
                    n_row = '0;
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                if (!center_wait) begin
                    n_row = r_row + 2'd1;
                    if (r_row == 2'd2) begin
                        n_row = '0;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid holds until the beat is taken.
    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        if (r_state == ST_OUT && (!r_ovalid || i_out_ready)) begin
            n_ovalid = 1'b1;
        end
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        o_cmd.row = r_row;
        o_cmd.load = accept;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_FOLD: o_cmd.fold = 1'b1;
            ST_CORDIC: o_cmd.cordic = 1'b1;
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                o_cmd.restart = (r_idx == '0);
            end
            ST_OFFSET: begin
                o_cmd.offset_full = !is_end;
                o_cmd.offset_half = is_end;
            end
            ST_MIX: o_cmd.mix = 1'b1;
            ST_CENTER: o_cmd.center = !center_wait;
            ST_OUT: o_cmd.load = 1'b0;
            default: o_cmd.load = accept;
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

@@ rtl/safk_dp.sv @@
// Datapath: CORDIC, transform stores, offset and mixing arithmetic.
module safk_dp
    import safk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [LenW-1:0] i_cfg_data,
    input  logic signed [AngleW-1:0] i_joint_angle,
    input  logic [IdxW-1:0] i_joint_index,
    input  t_cmd i_cmd,
    output t_status o_status,
    output logic signed [PosW-1:0] o_pos [3],
    output logic signed [RotW-1:0] o_rot [9]
);

    logic [LenW-1:0] r_len;
    logic signed [ZW-1:0] r_z;
    logic signed [RotW+1:0] r_x, r_y;
    logic r_flip;
    logic [StepW-1:0] r_k;
    logic r_odd;
    logic signed [RotW-1:0] r_c, r_s;
    logic signed [RotW-1:0] r_rot [9];
    logic signed [PosW-1:0] r_tr [3];
    logic signed [PosW-1:0] r_pos [3];
    logic signed [RotW-1:0] r_orot [9];

    // Link length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LinkReset;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // CORDIC iteration terms.
    logic signed [RotW+1:0] sx, sy;
    logic signed [RotW+1:0] fx, fy;
    assign sx = r_x >>> r_k;
    assign sy = r_y >>> r_k;
    assign fx = r_flip ? -r_x : r_x;
    assign fy = r_flip ? -r_y : r_y;

    function automatic logic signed [RotW-1:0] clamp_u(input logic signed [RotW+1:0] v);
        if (v > (RotW+2)'(OneQ16)) return OneQ16;
        if (v < -(RotW+2)'(OneQ16)) return -OneQ16;
        return v[RotW-1:0];
    endfunction

    assign o_status.cordic_last = (r_k == StepW'(CordicSteps - 1));

    // Offset: column-2 entry times link length, rounded, full or half.
    logic [1:0] row;
    logic [3:0] i0, i1, i2;
    logic signed [RotW+LenW:0] prod;
    logic signed [RotW+LenW:0] dfull, dhalf;
    logic signed [PosW:0] tsub;
    logic signed [PosW-1:0] tsat;
    assign row = i_cmd.row;
    assign i0 = 4'(row * 3);
    assign i1 = i0 + 4'd1;
    assign i2 = i0 + 4'd2;
    assign prod = r_rot[i2] * $signed({1'b0, r_len});
    assign dfull = (prod + (RotW+LenW+1)'(32768)) >>> 16;
    assign dhalf = (prod + (RotW+LenW+1)'(65536)) >>> 17;
    assign tsub = (PosW+1)'(r_tr[row]) - (PosW+1)'(dfull);
    assign tsat = (tsub > (PosW+1)'(2147483647)) ? 32'sh7fffffff :
                  (tsub < -(PosW+1)'(33'sd2147483648)) ? 32'sh80000000 : tsub[PosW-1:0];
    // Half offset: used for the link center and for the end effector step.
    logic signed [PosW:0] csub;
    logic signed [PosW-1:0] csat;
    assign csub = (PosW+1)'(r_tr[row]) - (PosW+1)'(dhalf);
    assign csat = (csub > (PosW+1)'(2147483647)) ? 32'sh7fffffff :
                  (csub < -(PosW+1)'(33'sd2147483648)) ? 32'sh80000000 : csub[PosW-1:0];

    // Mix: two products per new entry.
    logic signed [RotW-1:0] ma, mb, mn, mneg;
    logic signed [2*RotW-1:0] p_ac, p_bn, p_an, p_bc;
    logic signed [2*RotW+1:0] m0, m1;
    assign ma = r_rot[i0];
    assign mb = r_odd ? r_rot[i2] : r_rot[i1];
    assign mn = r_odd ? -r_s : r_s;
    assign mneg = -mn;
    assign p_ac = ma * r_c;
    assign p_bn = mb * mn;
    assign p_an = ma * mneg;
    assign p_bc = mb * r_c;
    assign m0 = (2*RotW+2)'(p_ac) + (2*RotW+2)'(p_bn) + (2*RotW+2)'(32768);
    assign m1 = (2*RotW+2)'(p_an) + (2*RotW+2)'(p_bc) + (2*RotW+2)'(32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_rot[k] <= (k % 4 == 0) ? OneQ16 : '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_tr[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_z <= ZW'(i_joint_angle) <<< 4;
                r_x <= (RotW+2)'(CordicGain);
                r_y <= '0;
                r_flip <= 1'b0;
                r_k <= '0;
                r_odd <= i_joint_index[0];
            end
            if (i_cmd.fold) begin
                if (r_z > HalfPiQ16) begin
                    r_z <= r_z - PiQ16;
                    r_flip <= !r_flip;
                end else if (r_z < -HalfPiQ16) begin
                    r_z <= r_z + PiQ16;
                    r_flip <= !r_flip;
                end
            end
            if (i_cmd.cordic) begin
                r_k <= r_k + 1'b1;
                if (r_z >= 0) begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - atan_q16(r_k);
                end else begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + atan_q16(r_k);
                end
            end
            if (i_cmd.fix) begin
                r_c <= clamp_u(fx);
                r_s <= clamp_u(fy);
                if (i_cmd.restart) begin
                    r_rot[0] <= clamp_u(fx);
                    r_rot[1] <= -clamp_u(fy);
                    r_rot[2] <= '0;
                    r_rot[3] <= clamp_u(fy);
                    r_rot[4] <= clamp_u(fx);
                    r_rot[5] <= '0;
                    r_rot[6] <= '0;
                    r_rot[7] <= '0;
                    r_rot[8] <= OneQ16;
                    for (int k = 0; k < 3; k++) begin
                        r_tr[k] <= '0;
                    end
                end
            end
            if (i_cmd.offset_full) begin
                r_tr[row] <= tsat;
            end else if (i_cmd.offset_half) begin
                r_tr[row] <= csat;
            end
            if (i_cmd.mix) begin
                r_rot[i0] <= clamp_u((RotW+2)'(m0 >>> 16));
                if (r_odd) begin
                    r_rot[i2] <= clamp_u((RotW+2)'(m1 >>> 16));
                end else begin
                    r_rot[i1] <= clamp_u((RotW+2)'(m1 >>> 16));
                end
            end
        end
    end

    // Link center and rotation snapshot for the result beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.center) begin
            r_pos[row] <= csat;
            if (row == 2'd2) begin
                r_orot <= r_rot;
            end
        end
    end

    assign o_pos = r_pos;
    assign o_rot = r_orot;

endmodule

@@ rtl/serial_arm_forward_kinematics.sv @@
// Top level: serial arm forward kinematics with handshake channels.
// A rotating joint runs from one accepted beat to the next through the accept
// step, fold steps, sixteen CORDIC iterations on one shared shift-add unit, a
// fix step, then link offset, rotation mixing and link-center output, each row
// by row over the three rows, and an output step. A restart joint skips offset
// and mix, and the end effector skips the mix. One item is in flight at a time.
// The next item may be accepted while a result still waits; its center step
// then holds until that result has been taken.
module serial_arm_forward_kinematics
    import safk_pkg::*;
#(
    parameter int unsigned NUM_JOINTS = 7
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [LenW-1:0] i_cfg_data,
    safk_in_if.sink i_in,
    safk_out_if.source o_out
);

    t_cmd cmd;
    t_status status;
    logic signed [PosW-1:0] pos [3];
    logic signed [RotW-1:0] rot [9];

    safk_ctrl #(.NUM_JOINTS(NUM_JOINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_joint_index(i_in.joint_index), .i_status(status), .o_cmd(cmd),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready)
    );

    safk_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_joint_angle(i_in.joint_angle), .i_joint_index(i_in.joint_index),
        .i_cmd(cmd), .o_status(status),
        .o_pos(pos), .o_rot(rot)
    );

    assign o_out.pos_x = pos[0];
    assign o_out.pos_y = pos[1];
    assign o_out.pos_z = pos[2];
    assign o_out.rot_00 = rot[0];
    assign o_out.rot_01 = rot[1];
    assign o_out.rot_02 = rot[2];
    assign o_out.rot_10 = rot[3];
    assign o_out.rot_11 = rot[4];
    assign o_out.rot_12 = rot[5];
    assign o_out.rot_20 = rot[6];
    assign o_out.rot_21 = rot[7];
    assign o_out.rot_22 = rot[8];

endmodule

@@ rtl/safk_checker.sv @@
// Checker: port-level properties of the kinematics block, bound to the top.
module safk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic signed [17:0] rot_22
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (rot_22 <= 18'sd65536 && rot_22 >= -18'sd65536))
        else $error("rotation entry out of range");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> ##1 !$rose(out_valid)) else $error("result too early");

endmodule

bind serial_arm_forward_kinematics safk_checker u_safk_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .rot_22(o_out.rot_22)
);
